>>> hdl/l2bh_pkg.sv
package l2bh_pkg;

  localparam logic [31:0] GOLDEN_WORD = 32'h9e37_79b9;

  // bytes held per 12-byte block before the twelfth arrives
  localparam int STORE_DEPTH = 11;
  localparam int FILL_W      = 4;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(STORE_DEPTH);

  localparam int ROW_W = 4;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(8);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_BLOCK       = 2'd0,  // absorb a full block, mix
    CMD_FINAL       = 2'd1,  // absorb tail, mix, emit c
    CMD_BLOCK_FINAL = 2'd2   // absorb full block, mix, mix again (empty tail), emit c
  } cmd_kind_e;

  typedef struct packed {
    logic        first;   // first transaction of a key: start from golden words and seed
    cmd_kind_e   kind;
    logic [31:0] seed;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
  } cmd_t;

  typedef struct packed {
    logic q_pop;
    logic res_wr;
  } bk_stat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  // One row of the lookup2 mix per call.
  function automatic words_t mix_row(input words_t w, input logic [ROW_W-1:0] row);
    words_t r;
    r = w;
    unique case (row)
      4'd0: begin r.a = w.a - w.b - w.c; r.a = r.a ^ (w.c >> 13); end
      4'd1: begin r.b = w.b - w.c - w.a; r.b = r.b ^ (w.a << 8);  end
      4'd2: begin r.c = w.c - w.a - w.b; r.c = r.c ^ (w.b >> 13); end
      4'd3: begin r.a = w.a - w.b - w.c; r.a = r.a ^ (w.c >> 12); end
      4'd4: begin r.b = w.b - w.c - w.a; r.b = r.b ^ (w.a << 16); end
      4'd5: begin r.c = w.c - w.a - w.b; r.c = r.c ^ (w.b >> 5);  end
      4'd6: begin r.a = w.a - w.b - w.c; r.a = r.a ^ (w.c >> 3);  end
      4'd7: begin r.b = w.b - w.c - w.a; r.b = r.b ^ (w.a << 10); end
      4'd8: begin r.c = w.c - w.a - w.b; r.c = r.c ^ (w.b >> 15); end
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/l2bh_front.sv
module l2bh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     key_byte_i,
  input  logic           byte_present_i,
  input  logic           last_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_initial_c_i,
  output logic           cmd_push_o,
  output l2bh_pkg::cmd_t cmd_o
);
  import l2bh_pkg::*;

  logic [7:0]        store_q [STORE_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              in_key_q, in_key_d;
  logic              started_q, started_d;
  logic [31:0]       initial_c_q;
  logic [31:0]       seed_q;

  logic [7:0]        view [STORE_DEPTH];
  logic [7:0]        tail [STORE_DEPTH];
  logic [FILL_W-1:0] n_tail;
  logic              full_blk;

  assign full_blk = byte_present_i && (fill_q == FILL_LAST);
  assign n_tail   = fill_q + {{(FILL_W-1){1'b0}}, byte_present_i};

  // incoming byte merged into its slot, then masked to the bytes of the tail
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (byte_present_i && fill_q == FILL_W'(i)) ? key_byte_i : store_q[i];
      tail[i] = (FILL_W'(i) < n_tail) ? view[i] : 8'h00;
    end
  end

  always_comb begin
    cmd_push_o  = accept_i && (full_blk || last_i);
    cmd_o.first = !started_q;
    cmd_o.seed  = in_key_q ? seed_q : initial_c_q;
    if (full_blk) begin
      cmd_o.kind  = last_i ? CMD_BLOCK_FINAL : CMD_BLOCK;
      cmd_o.add_a = {store_q[3], store_q[2], store_q[1], store_q[0]};
      cmd_o.add_b = {store_q[7], store_q[6], store_q[5], store_q[4]};
      cmd_o.add_c = {key_byte_i, store_q[10], store_q[9], store_q[8]};
    end else begin
      cmd_o.kind  = CMD_FINAL;
      cmd_o.add_a = {tail[3], tail[2], tail[1], tail[0]};
      cmd_o.add_b = {tail[7], tail[6], tail[5], tail[4]};
      // tail bytes 8..10 sit one byte up; the low byte carries the remainder length
      cmd_o.add_c = {tail[10], tail[9], tail[8], {(8-FILL_W){1'b0}}, n_tail};
    end
  end

  always_comb begin
    fill_d    = fill_q;
    in_key_d  = in_key_q;
    started_d = started_q;
    if (accept_i) begin
      if (last_i || full_blk) begin
        fill_d = '0;
      end else if (byte_present_i) begin
        fill_d = fill_q + 1'b1;
      end
      if (last_i) begin
        in_key_d = 1'b0;
      end else if (byte_present_i) begin
        in_key_d = 1'b1;
      end
      if (cmd_push_o) begin
        started_d = !last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      in_key_q    <= 1'b0;
      started_q   <= 1'b0;
      initial_c_q <= '0;
    end else begin
      fill_q    <= fill_d;
      in_key_q  <= in_key_d;
      started_q <= started_d;
      if (cfg_we_i) begin
        initial_c_q <= cfg_initial_c_i;
      end
    end
  end

  // seed latched when a key takes its first byte; later writes wait for the next key
  always_ff @(posedge clk_i) begin
    if (accept_i && !in_key_q) begin
      seed_q <= initial_c_q;
    end
    if (accept_i && byte_present_i && !full_blk) begin
      store_q[fill_q] <= key_byte_i;
    end
  end

endmodule

>>> hdl/l2bh_cmdq.sv
module l2bh_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  l2bh_pkg::cmd_t data_i,
  input  logic           pop_i,
  output l2bh_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import l2bh_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o  = entry_q[rd_q];
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hdl/l2bh_back.sv
module l2bh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  l2bh_pkg::cmd_t     head_i,
  input  logic               q_empty_i,
  input  logic               pop_i,
  output l2bh_pkg::bk_stat_t stat_o,
  output logic               res_valid_o,
  output logic [31:0]        res_o
);
  import l2bh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MIX  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             fin_q, fin_d;
  logic             again_q, again_d;
  words_t           w_q, w_d, mixed, base;
  logic [31:0]      res_q, res_d;
  logic             rv_q, rv_d;
  logic             pop_acc, slot_free;

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    base.a = head_i.first ? GOLDEN_WORD : w_q.a;
    base.b = head_i.first ? GOLDEN_WORD : w_q.b;
    base.c = head_i.first ? head_i.seed : w_q.c;
    mixed  = mix_row(w_q, row_q);
  end

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    fin_d         = fin_q;
    again_d       = again_q;
    w_d           = w_q;
    res_d         = res_q;
    stat_o.q_pop  = 1'b0;
    stat_o.res_wr = 1'b0;
    pop_acc       = pop_i && rv_q;
    slot_free     = !rv_q || pop_acc;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          stat_o.q_pop = 1'b1;
          w_d.a   = base.a + head_i.add_a;
          w_d.b   = base.b + head_i.add_b;
          w_d.c   = base.c + head_i.add_c;
          row_d   = '0;
          fin_d   = (head_i.kind != CMD_BLOCK);
          again_d = (head_i.kind == CMD_BLOCK_FINAL);
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        w_d = mixed;
        if (row_q != LAST_ROW) begin
          row_d = row_q + 1'b1;
        end else if (again_q) begin
          // key ended on a block boundary: empty tail, mix once more
          row_d   = '0;
          again_d = 1'b0;
        end else if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          res_d         = mixed.c;
          stat_o.res_wr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          res_d         = w_q.c;
          stat_o.res_wr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    rv_d = stat_o.res_wr || (rv_q && !pop_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      fin_q   <= 1'b0;
      again_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      fin_q   <= fin_d;
      again_q <= again_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    res_q <= res_d;
  end

endmodule

>>> hdl/lookup2_byte_hash_top.sv
// Channel   Dir  Handshake                   Payload
// key in    in   push / full                 key_byte, byte_present, last
// hash out  out  empty / pop                 hash_value
// seed cfg  in   cfg_valid_i / cfg_ready_o   cfg_initial_c_i (initial_c)
//
// Key bytes are taken one per cycle while full is low; each 12-byte block and each key end
// is one transaction to the mix unit: an absorb step, then 9 mix rows, run twice on a
// block-boundary end. Long keys stream at 1 byte/cycle; short keys are paced by the mix
// unit. Reset clears control state and the seed to 0. full rises only when the 2-entry
// queue is full; a waiting hash holds the mix unit only once a second is ready.
module lookup2_byte_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // key byte channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  // hash result channel
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value_o,
  // seed register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_initial_c_i
);
  import l2bh_pkg::*;

  logic     in_acc;
  logic     cmd_push;
  cmd_t     cmd, head;
  logic     q_full, q_empty;
  bk_stat_t bk_stat;
  logic     res_valid;

  // seed register is always writable; a mid-key write only affects the next key
  assign cfg_ready_o = 1'b1;

  // front stalls as a whole while the queue is full, so full never depends on push
  assign full   = q_full;
  assign in_acc = push && !q_full;
  assign empty  = !res_valid;

  // front: packs bytes, tracks fill and key state, builds block/final transactions
  l2bh_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (in_acc),
    .key_byte_i,
    .byte_present_i,
    .last_i,
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_initial_c_i,
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd)
  );

  // decouples the byte stream from the multi-cycle mix
  l2bh_cmdq u_cmdq (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd),
    .pop_i   (bk_stat.q_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: holds words a/b/c, absorbs and mixes, parks the hash in the result register
  l2bh_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_i       (pop),
    .stat_o      (bk_stat),
    .res_valid_o (res_valid),
    .res_o       (hash_value_o)
  );

  // no transaction is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !q_full)
    else $error("transaction pushed into full queue");

  // mix unit only takes a transaction that is there
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a waiting hash is never overwritten
  a_no_res_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.res_wr |-> (empty || pop))
    else $error("result overwritten before pop");

  // a popped hash leaves unless a new one is written in the same cycle
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !bk_stat.res_wr) |=> empty)
    else $error("result still present after pop");

endmodule

>>> test/tb_lookup2_byte_hash_top.sv
`timescale 1ns / 100ps

module tb_lookup2_byte_hash_top;

  import l2bh_pkg::GOLDEN_WORD;

  // Longest run of cycles with no transaction on any channel before the run is called hung.
  // The worst legal quiet stretch is the drain pause (DRAIN_CYCLES). Next comes a
  // block-boundary key end in the mix unit plus a receiver stall plus a sender gap.
  localparam int WATCHDOG_LIMIT = 1000;
  // Long enough for a hash to leave an idle mix unit, also on a block boundary; ample margin.
  localparam int DRAIN_CYCLES   = 40;
  localparam int STALL_EPOCH    = 97;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hash_words_t;

  // how a key is terminated: last on the final byte, or a separate byte-less marker
  typedef enum logic {
    END_ON_BYTE,
    END_ON_MARKER
  } key_end_e;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  key_byte_i;
  logic        byte_present_i;
  logic        last_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] hash_value_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_initial_c_i;

  lookup2_byte_hash_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .key_byte_i     (key_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .empty          (empty),
    .pop            (pop),
    .hash_value_o   (hash_value_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_initial_c_i(cfg_initial_c_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Hash predictor: mirrors the key state of the block
  // ---------------------------------------------------------------------------
  hash_words_t key_words;
  logic [7:0]  key_bytes [0:10];   // bytes of the current 12-byte block, minus the 12th
  int unsigned key_fill;
  bit          key_open;           // at least one byte of the current key taken
  logic [31:0] seed_value;

  logic [31:0] pending_hashes [$];

  int error_count    = 0;
  int hashes_checked = 0;
  int keys_sent      = 0;
  int items_sent     = 0;          // byte or end-of-key transactions, idles not counted
  int seed_writes    = 0;

  // Full nine-row lookup2 mix.
  function automatic hash_words_t lookup2_mix(input hash_words_t w);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    hash_words_t r;
    a = w.a;
    b = w.b;
    c = w.c;
    a = a - b - c; a = a ^ (c >> 13);
    b = b - c - a; b = b ^ (a << 8);
    c = c - a - b; c = c ^ (b >> 13);
    a = a - b - c; a = a ^ (c >> 12);
    b = b - c - a; b = b ^ (a << 16);
    c = c - a - b; c = c ^ (b >> 5);
    a = a - b - c; a = a ^ (c >> 3);
    b = b - c - a; b = b ^ (a << 10);
    c = c - a - b; c = c ^ (b >> 15);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  // little-endian lane: byte idx in its position within a 32-bit word
  function automatic logic [31:0] block_lane(input int idx);
    return {24'h0, key_bytes[idx]} << (8 * (idx % 4));
  endfunction

  function automatic void restart_key();
    key_words.a = GOLDEN_WORD;
    key_words.b = GOLDEN_WORD;
    key_words.c = seed_value;
    key_fill    = 0;
    key_open    = 1'b0;
  endfunction

  // Advance the predictor by one accepted key transaction.
  function automatic void predict_hash(input logic [7:0] kb, input logic bp, input logic lst);
    int i;
    if (bp) begin
      key_open = 1'b1;
      if (key_fill >= 11) begin
        // twelfth byte: absorb the whole block and mix right away
        for (i = 0; i < 4; i++) begin
          key_words.a += block_lane(i);
          key_words.b += block_lane(i + 4);
        end
        key_words.c += block_lane(8) + block_lane(9) + block_lane(10) + ({24'h0, kb} << 24);
        key_words = lookup2_mix(key_words);
        key_fill  = 0;
      end else begin
        key_bytes[key_fill] = kb;
        key_fill++;
      end
    end
    if (lst) begin
      // tail: remainder length into c, bytes 8..10 sit one byte higher in c
      key_words.c += key_fill;
      for (i = 0; i < key_fill; i++) begin
        if (i < 4)
          key_words.a += block_lane(i);
        else if (i < 8)
          key_words.b += block_lane(i);
        else
          key_words.c += {24'h0, key_bytes[i]} << (8 * (i - 7));
      end
      key_words = lookup2_mix(key_words);
      pending_hashes.push_back(key_words.c);
      keys_sent++;
      restart_key();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Hash result checker: every popped hash against the oldest prediction
  // ---------------------------------------------------------------------------
  logic [31:0] expected_hash;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value: unexpected result %08h, no hash pending", hash_value_o);
        error_count++;
      end else begin
        expected_hash = pending_hashes.pop_front();
        hashes_checked++;
        if (hash_value_o !== expected_hash) begin
          $error("hash_value mismatch: expected %08h, actual %08h", expected_hash,
                 hash_value_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop follows a rotating 16-bit pattern, reloaded every epoch.
  // One epoch in four never stalls; the pattern always holds a one and a fresh
  // pattern starts with a pop, so a stall never lasts a full turn of the pattern.
  // ---------------------------------------------------------------------------
  logic [15:0] pop_pattern = 16'hFFFF;
  int          stall_epoch = 0;

  always @(posedge clk_i) begin
    stall_epoch++;
    if (stall_epoch == STALL_EPOCH) begin
      stall_epoch = 0;
      if ($urandom_range(0, 3) == 0)
        pop_pattern = 16'hFFFF;
      else
        pop_pattern = 16'($urandom) | 16'h0002;
    end
    pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
    pop <= pop_pattern[0];
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any accepted transaction on any channel restarts the count
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d hashes pending",
               WATCHDOG_LIMIT, pending_hashes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left     = 0;
  bit sender_bursty  = 1'b1;   // 0: push every cycle, full is the only brake

  // Drive one key transaction and wait for it to be accepted. push stays high
  // across a burst; it only drops for a gap between bursts.
  task automatic send_item(input logic [7:0] kb, input logic bp, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_bursty && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    push           <= 1'b1;
    key_byte_i     <= kb;
    byte_present_i <= bp;
    last_i         <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    if (bp || lst) items_sent++;
    predict_hash(kb, bp, lst);
  endtask

  // One key of len random bytes, with the odd idle transaction mixed in.
  task automatic send_key(input int len, input key_end_e how);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (how == END_ON_BYTE) && (i == len - 1));
    end
    // empty key or byte-less end marker
    if (len == 0 || how == END_ON_MARKER) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly short and mid keys; a few long ones to run several blocks.
  function automatic int pick_key_length(input bit short_keys);
    int r;
    if (short_keys) return $urandom_range(0, 4);
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(0, 26);
    if (r < 19) return $urandom_range(27, 48);
    return $urandom_range(49, 96);
  endfunction

  task automatic run_random_keys(input int target, input bit short_keys);
    int       start;
    key_end_e how;
    start = items_sent;
    while (items_sent - start < target) begin
      how = ($urandom_range(0, 2) == 0) ? END_ON_MARKER : END_ON_BYTE;
      send_key(pick_key_length(short_keys), how);
      // noise between keys
      if ($urandom_range(0, 5) == 0) send_item(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // Seed writes only land while the block is idle: all hashes back, then a
  // pause long enough for any transaction still in the mix unit.
  task automatic write_seed(input logic [31:0] value);
    push       <= 1'b0;
    burst_left = 0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_initial_c_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    seed_value = value;
    if (!key_open) key_words.c = value;
    seed_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset seed of 0: empty key, idle, single byte with last, byte then a
  // separate end marker, and a key that ends exactly on a block boundary.
  task automatic test_directed_edges();
    int i;
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    for (i = 0; i < 12; i++) send_item(8'hFF, 1'b1, i == 11);
  endtask

  task automatic test_seed_all_ones();
    write_seed(32'hFFFF_FFFF);
    run_random_keys(180, 1'b0);
  endtask

  // seed of 2
  task automatic test_seed_two();
    write_seed(32'h0000_0002);
    run_random_keys(180, 1'b0);
  endtask

  task automatic test_random_seeds();
    int n;
    for (n = 0; n < 3; n++) begin
      write_seed($urandom);
      run_random_keys(150, 1'b0);
    end
  endtask

  // Short keys pushed every cycle so the transaction queue fills and full backs up.
  task automatic test_back_to_back_keys();
    write_seed(32'h0000_0000);
    sender_bursty = 1'b0;
    run_random_keys(150, 1'b1);
    sender_bursty = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    key_byte_i      = 8'h00;
    byte_present_i  = 1'b0;
    last_i          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_initial_c_i = 32'h0;
    seed_value      = 32'h0;
    restart_key();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_seed_all_ones();
    test_seed_two();
    test_random_seeds();
    test_back_to_back_keys();

    push <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d keys in %0d key transactions over %0d seed settings",
             keys_sent, items_sent, seed_writes + 1);
    $display("Checked %0d hashes, %0d errors", hashes_checked, error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
